FILE: rtl/core/gbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_pkg: shared types and codes of the gyro bias calibrator
// Function selectors, result status codes, register indexes and the
// structures that pass between the lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int RATE_W     = 17;
  localparam int STATUS_W   = 3;
  localparam int FUNC_W     = 2;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_AXES   = 3;
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [FUNC_W-1:0] FUNC_MEAS    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CAL     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_CALIBRATED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CONTINUING = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_COMM_ERROR = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READY      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_DEV_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TIME = 1'd1;

  localparam logic [CFG_W-1:0] DEV_LIMIT_RESET   = 16'd200;
  localparam logic [CFG_W-1:0] SAMPLE_TIME_RESET = 16'd256;

  typedef struct packed {
    logic busy;
    logic over;
  } lane_stat_t;

  typedef struct packed {
    logic                set_reseed;
    logic                count_inc;
    logic [STATUS_W-1:0] status;
  } merge_t;

endpackage

FILE: rtl/core/gbc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_ifs: valid/ready channels of the gyro bias calibrator
// One channel carries a finished gyro transfer, the other a result beat.
// ----------------------------------------------------------------------------
interface gbc_item_if
  import gbc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic                       comm_error;
  logic                       complete;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;
  logic signed [SAMPLE_W-1:0] sample_z;

  modport source (output valid, func, comm_error, complete, sample_x, sample_y, sample_z,
                  input ready);
  modport sink (input valid, func, comm_error, complete, sample_x, sample_y, sample_z,
                output ready);
endinterface

interface gbc_result_if
  import gbc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [RATE_W-1:0] rate_x;
  logic signed [RATE_W-1:0] rate_y;
  logic signed [RATE_W-1:0] rate_z;

  modport source (output valid, status, rate_x, rate_y, rate_z, input ready);
  modport sink (input valid, status, rate_x, rate_y, rate_z, output ready);
endinterface

FILE: rtl/core/gbc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_lane: one axis of the calibrator
// Holds the axis bias, checks the deviation of a sample and divides the
// signed difference by the sample time with a restoring divider.
// ----------------------------------------------------------------------------
module gbc_lane
  import gbc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       load,
  input  logic                       commit,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [CFG_W-1:0]           limit,
  input  logic [CFG_W-1:0]           divisor,
  output logic signed [SAMPLE_W-1:0] bias,
  output lane_stat_t                 stat
);

  logic                 neg;
  logic                 over;
  logic                 busy;
  logic [SAMPLE_W:0]    rem;
  logic [SAMPLE_W-1:0]  quo;
  logic [DIV_CNT_W-1:0] cnt;

  logic signed [SAMPLE_W:0] diff;
  logic signed [SAMPLE_W:0] mag;
  logic [SAMPLE_W:0]        rem_sh;
  logic                     fits;
  logic signed [SAMPLE_W:0] quo_signed;

  assign diff       = {sample[SAMPLE_W-1], sample} - {bias[SAMPLE_W-1], bias};
  assign mag        = diff[SAMPLE_W] ? -diff : diff;
  assign rem_sh     = {rem[SAMPLE_W-1:0], quo[SAMPLE_W-1]};
  assign fits       = rem_sh >= {1'b0, divisor};
  assign quo_signed = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  assign stat.busy = busy;
  assign stat.over = over;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      // The magnitude of a 16-bit difference never exceeds 65535.
      neg  <= diff[SAMPLE_W];
      over <= mag[SAMPLE_W-1:0] > limit;
      quo  <= mag[SAMPLE_W-1:0];
      rem  <= '0;
      cnt  <= DIV_CNT_W'(DIV_STEPS);
      busy <= 1'b1;
    end else if (busy) begin
      rem  <= fits ? rem_sh - {1'b0, divisor} : rem_sh;
      quo  <= {quo[SAMPLE_W-2:0], fits};
      cnt  <= cnt - 1'b1;
      busy <= cnt != DIV_CNT_W'(1);
    end else if (load) begin
      bias <= sample;
    end else if (commit) begin
      // The new bias lies between the old bias and the sample, so it fits.
      bias <= bias + quo_signed[SAMPLE_W-1:0];
    end
  end

endmodule

FILE: rtl/core/gbc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_merge: combines the lane findings of a calibration sample
// Axes are taken in order; the first axis out of range stops the update of
// itself and of every later axis and schedules a restart.
// ----------------------------------------------------------------------------
module gbc_merge
  import gbc_pkg::*;
#(
  parameter int AXES = 3
) (
  input  logic [AXES-1:0]  over,
  input  logic [CFG_W-1:0] settled_count,
  input  logic [CFG_W-1:0] target,
  output logic [AXES-1:0]  commit,
  output merge_t           res
);

  always_comb begin
    logic clean;
    clean = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      clean     = clean & ~over[i];
      commit[i] = clean;
    end
    res.set_reseed = ~clean;
    res.count_inc  = clean && (settled_count < target);
    res.status     = (clean && (settled_count >= target)) ? ST_CALIBRATED : ST_CONTINUING;
  end

endmodule

FILE: rtl/core/gyro_bias_calibrator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_bias_calibrator_unit: gyro bias calibration by running average
// Takes finished three-axis gyro transfers, tracks a per-axis bias during
// calibration and returns bias-corrected rates on measurement transfers.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Beat contents
//  --------  ---------  -----------------  -------------------------------------
//  item      in         valid / ready      func, comm_error, complete, samples
//  result    out        valid / ready      status, rate_x, rate_y, rate_z
//  wr        in         wr_en, no stall    wr_index, wr_data (16 bit)
//
//  A calibration sample that runs through the divider goes from its item
//  beat to the earliest result beat by starting the lanes, 16 steps of
//  the per-lane restoring divider, the sequencer seeing the lanes finish,
//  the merge, loading the output register and the beat itself. Every
//  other item goes from the start state straight to the output register.
//  One item is in work at a time, so the divider sets the rate of calibration.
//  Reset is synchronous: it clears the biases, the count, sets the restart
//  flag and loads the register defaults.
//  A stalled result stays in the output register while the next item is
//  taken and worked on; that item's result waits until the register frees.
//
module gyro_bias_calibrator_unit
  import gbc_pkg::*;
#(
  parameter int AXES = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  gbc_item_if.sink             item,
  gbc_result_if.source         result,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state;

  // Configuration registers.
  logic [CFG_W-1:0] dev_limit;
  logic [CFG_W-1:0] avg_len;
  logic [CFG_W-1:0] target;

  // Calibration state outside the lanes.
  logic [CFG_W-1:0] settled_count;
  logic             reseed;

  // The item in work.
  logic [FUNC_W-1:0]          func_q;
  logic                       err_q;
  logic                       full_q;
  logic signed [SAMPLE_W-1:0] samp_q [MAX_AXES];

  // Result waiting to enter the output register, and the register itself.
  logic [STATUS_W-1:0]      res_status;
  logic signed [RATE_W-1:0] res_rate [MAX_AXES];
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic signed [RATE_W-1:0] out_rate [MAX_AXES];

  logic signed [SAMPLE_W-1:0] bias_all [MAX_AXES];
  lane_stat_t                 lane_stat [AXES];
  logic [AXES-1:0]            lane_over;
  logic [AXES-1:0]            lane_commit;
  logic                       lanes_busy;
  logic                       lane_start;
  logic                       lane_load;
  logic                       merge_apply;
  logic                       meas_ok;
  merge_t                     merge_res;
  logic                       accept;
  logic                       emit;

  // A sample time of zero behaves as one, both as divisor and as target.
  assign target = (avg_len == '0) ? CFG_W'(1) : avg_len;

  assign accept      = item.valid && item.ready;
  assign item.ready  = state == S_IDLE;
  assign emit        = (state == S_EMIT) && (!out_valid || result.ready);
  assign lane_start  = (state == S_EXEC) && (func_q == FUNC_CAL) && !err_q && full_q && !reseed;
  assign lane_load   = (state == S_EXEC) && (func_q == FUNC_CAL) && !err_q && full_q && reseed;
  assign merge_apply = state == S_MERGE;
  // A clean, complete measurement is the only item that carries rates.
  assign meas_ok     = (func_q == FUNC_MEAS) && !err_q && full_q;

  for (genvar i = 0; i < MAX_AXES; i++) begin : g_axis
    if (i < AXES) begin : g_lane
      gbc_lane u_lane (
        .clk     (clk),
        .rst     (rst),
        .start   (lane_start),
        .load    (lane_load),
        .commit  (merge_apply && lane_commit[i]),
        .sample  (samp_q[i]),
        .limit   (dev_limit),
        .divisor (target),
        .bias    (bias_all[i]),
        .stat    (lane_stat[i])
      );
      assign lane_over[i] = lane_stat[i].over;
    end else begin : g_absent
      assign bias_all[i] = '0;
    end
  end

  always_comb begin
    lanes_busy = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      lanes_busy = lanes_busy | lane_stat[i].busy;
    end
  end

  gbc_merge #(
    .AXES (AXES)
  ) u_merge (
    .over          (lane_over),
    .settled_count (settled_count),
    .target        (target),
    .commit        (lane_commit),
    .res           (merge_res)
  );

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_limit <= DEV_LIMIT_RESET;
      avg_len   <= SAMPLE_TIME_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_DEV_LIMIT:   dev_limit <= wr_data;
        CFG_SAMPLE_TIME: avg_len   <= wr_data;
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q    <= item.func;
      err_q     <= item.comm_error;
      full_q    <= item.complete;
      samp_q[0] <= item.sample_x;
      samp_q[1] <= item.sample_y;
      samp_q[2] <= item.sample_z;
    end
  end

  // Sequencer. Only axes that exist give a rate; the rest stay zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      settled_count <= '0;
      reseed        <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // Only a calibration sample against a settled bias needs the divider.
          state <= lane_start ? S_DIV : S_EMIT;
          for (int i = 0; i < MAX_AXES; i++) begin
            if (meas_ok && (i < AXES)) begin
              res_rate[i] <= {samp_q[i][SAMPLE_W-1], samp_q[i]}
                           - {bias_all[i][SAMPLE_W-1], bias_all[i]};
            end else begin
              res_rate[i] <= '0;
            end
          end
          if (func_q == FUNC_RESTART) begin
            reseed     <= 1'b1;
            res_status <= ST_CONTINUING;
          end else if (func_q == FUNC_UNUSED) begin
            res_status <= ST_INVALID;
          end else if (err_q) begin
            res_status <= ST_COMM_ERROR;
          end else if (!full_q) begin
            res_status <= ST_INVALID;
          end else begin
            case (func_q)
              FUNC_CAL: begin
                res_status <= ST_CONTINUING;
                if (reseed) begin
                  settled_count <= '0;
                  reseed        <= 1'b0;
                end
              end
              default: begin
                res_status <= ST_READY;
              end
            endcase
          end
        end
        S_DIV: begin
          if (!lanes_busy) begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          res_status <= merge_res.status;
          if (merge_res.set_reseed) begin
            reseed <= 1'b1;
          end
          if (merge_res.count_inc) begin
            settled_count <= settled_count + 1'b1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: it parts the result channel from the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status <= res_status;
      for (int i = 0; i < MAX_AXES; i++) begin
        out_rate[i] <= res_rate[i];
      end
    end
  end

  assign result.valid  = out_valid;
  assign result.status = out_status;
  assign result.rate_x = out_rate[0];
  assign result.rate_y = out_rate[1];
  assign result.rate_z = out_rate[2];

endmodule

FILE: rtl/core/gbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_checker: port-level checks of the gyro bias calibrator
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
module gbc_checker
  import gbc_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     item_valid,
  input logic                     item_ready,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic [STATUS_W-1:0]      res_status,
  input logic signed [RATE_W-1:0] res_rate_x,
  input logic signed [RATE_W-1:0] res_rate_y,
  input logic signed [RATE_W-1:0] res_rate_z
);

  // A result beat that is held back keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_rate_x)
                                && $stable(res_rate_y) && $stable(res_rate_z))
    else $error("stalled result beat changed");

  // Only one item is in work: an item beat closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input open right after an item beat");

  // Rates are carried only with data ready.
  a_zero_rates: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_READY |-> res_rate_x == '0 && res_rate_y == '0
                                            && res_rate_z == '0)
    else $error("rates on a result without data");

  // No result can leave before its item has passed the start and emit states.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !res_valid |=> !res_valid ##1 !res_valid)
    else $error("result beat too early");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind gyro_bias_calibrator_unit gbc_checker u_gbc_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_status (result.status),
  .res_rate_x (result.rate_x),
  .res_rate_y (result.rate_y),
  .res_rate_z (result.rate_z)
);

FILE: tb/gbc_rate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_rate_checker: result predictor and comparator of the gyro bias calibrator
// Follows register writes and accepted item beats, keeps its own copy of the
// per-axis bias and calibration count, and checks each accepted result beat
// against the oldest expected one.
// ----------------------------------------------------------------------------
module gbc_rate_checker
  import gbc_pkg::*;
#(
  parameter int AXES = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  gbc_item_if                  item,
  gbc_result_if                result,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
  } rate_beat_t;

  rate_beat_t expected_rates[$];

  int dev_limit;
  int avg_len;
  int bias[MAX_AXES];
  int settled;
  bit reseed;
  int mismatches = 0;
  int waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  function automatic logic [STATUS_W-1:0] calibrate_step(input int smp[MAX_AXES]);
    int target;
    int diff;
    int mag;
    target = (avg_len == 0) ? 1 : avg_len;
    if (reseed) begin
      for (int i = 0; i < AXES; i++) bias[i] = smp[i];
      settled = 0;
      reseed  = 1'b0;
      return ST_CONTINUING;
    end
    // Axes before a failing one keep their new bias.
    for (int i = 0; i < AXES; i++) begin
      diff = smp[i] - bias[i];
      mag  = (diff < 0) ? -diff : diff;
      if (mag > dev_limit) begin
        reseed = 1'b1;
        return ST_CONTINUING;
      end
      bias[i] += diff / target;
    end
    if (settled >= target) return ST_CALIBRATED;
    settled = (settled + 1) & 16'hFFFF;
    return ST_CONTINUING;
  endfunction

  function automatic rate_beat_t predict_rates(input logic [FUNC_W-1:0] f, input logic ce,
                                               input logic cp, input int smp[MAX_AXES]);
    rate_beat_t r;
    int         d[MAX_AXES];
    r = '0;
    d = '{0, 0, 0};
    if (f == FUNC_RESTART) begin
      reseed   = 1'b1;
      r.status = ST_CONTINUING;
    end else if (f == FUNC_UNUSED) begin
      r.status = ST_INVALID;
    end else if (ce) begin
      r.status = ST_COMM_ERROR;
    end else if (!cp) begin
      r.status = ST_INVALID;
    end else if (f == FUNC_CAL) begin
      r.status = calibrate_step(smp);
    end else begin
      for (int i = 0; i < AXES; i++) d[i] = smp[i] - bias[i];
      r.status = ST_READY;
    end
    r.rate_x = RATE_W'(d[0]);
    r.rate_y = RATE_W'(d[1]);
    r.rate_z = RATE_W'(d[2]);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rate_beat_t want;
    int         smp[MAX_AXES];
    if (rst) begin
      dev_limit = DEV_LIMIT_RESET;
      avg_len   = SAMPLE_TIME_RESET;
      bias      = '{0, 0, 0};
      settled   = 0;
      reseed    = 1'b1;
      expected_rates.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          CFG_DEV_LIMIT:   dev_limit = wr_data;
          CFG_SAMPLE_TIME: avg_len   = wr_data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (expected_rates.size() == 0) begin
          $display("%0t: unexpected result beat, status %0d", $time, result.status);
          mismatches++;
        end else begin
          want = expected_rates.pop_front();
          if (result.status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status,
                     result.status);
            mismatches++;
          end
          if (result.rate_x !== want.rate_x) begin
            $display("%0t: rate_x expected %0d, actual %0d", $time, want.rate_x,
                     result.rate_x);
            mismatches++;
          end
          if (result.rate_y !== want.rate_y) begin
            $display("%0t: rate_y expected %0d, actual %0d", $time, want.rate_y,
                     result.rate_y);
            mismatches++;
          end
          if (result.rate_z !== want.rate_z) begin
            $display("%0t: rate_z expected %0d, actual %0d", $time, want.rate_z,
                     result.rate_z);
            mismatches++;
          end
        end
      end
      if (item.valid && item.ready) begin
        smp[0] = int'(item.sample_x);
        smp[1] = int'(item.sample_y);
        smp[2] = int'(item.sample_z);
        expected_rates.push_back(predict_rates(item.func, item.comm_error, item.complete,
                                               smp));
      end
    end
    waiting = expected_rates.size();
  end

endmodule

FILE: tb/gyro_bias_calibrator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_bias_calibrator_unit_tb: testbench of the gyro bias calibrator
// Drives a directed run over the flag, selector and calibration corner cases,
// then phases of random transfers under several register settings, with
// random idling on both channels and one long result hold-off. A checker
// beside the block predicts every result beat and counts mismatches.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator_unit_tb;
  import gbc_pkg::*;

  // Chance in percent that a side idles in a given cycle.
  localparam int IDLE_PCT = 27;
  // Length of the long result hold-off that fills the block up.
  localparam int HOLD_CYCLES = 300;
  // Cycles without any accepted beat before the run is declared hung. This
  // covers the hold-off and any plausible run of idle cycles many times over.
  localparam int STALL_LIMIT = 4000;
  // Quiet time at the end.
  localparam int TAIL_CYCLES = 40;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0]     wr_data = '0;

  gbc_item_if   item ();
  gbc_result_if result ();

  int fail_count;
  int pending;

  // Stimulus controls used by the sender, the receiver and the main process.
  bit steady = 1'b0;
  int holds_asked = 0;
  int center[MAX_AXES];

  logic item_fire = 1'b0;
  int   quiet_cycles = 0;

  gyro_bias_calibrator_unit #(
    .AXES(3)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .result  (result),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data)
  );

  gbc_rate_checker #(
    .AXES(3)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The posedge samples see the values from before the edge, so this flag
  // tells the sender, at the following falling edge, whether its beat went in.
  always @(posedge clk) begin
    item_fire <= item.valid && item.ready;
  end

  // Watchdog: a run that stops moving beats is a failure.
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side. Ready drops at random unless the steady stretch is on. When
  // the main process asks for a hold-off, ready stays low for HOLD_CYCLES
  // counted here, while the sender keeps offering beats.
  initial begin : receiver
    int holds_done = 0;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        result.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      result.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offers one item beat, called at a falling edge, and returns at the falling
  // edge after the beat has been taken, with valid still high.
  task automatic send_beat(input logic [FUNC_W-1:0] f, input logic ce, input logic cp,
                           input int x, input int y, input int z);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      item.valid <= 1'b0;
      @(negedge clk);
    end
    item.valid      <= 1'b1;
    item.func       <= f;
    item.comm_error <= ce;
    item.complete   <= cp;
    item.sample_x   <= SAMPLE_W'(x);
    item.sample_y   <= SAMPLE_W'(y);
    item.sample_z   <= SAMPLE_W'(z);
    do @(negedge clk); while (!item_fire);
  endtask

  // Registers may only change with the block idle: stop offering beats and
  // wait for every outstanding result. Each item has a result, so once the
  // last one is in, nothing is left in work.
  task automatic drain();
    item.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= CFG_W'(val);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // One random beat. Most are clean calibration samples scattered around a
  // per-axis center well inside the deviation limit, so calibration can run
  // all the way to success. Churn covers restarts, calibration samples far
  // outside the limit, and fully random selectors, flags and samples.
  task automatic random_beat(input int dev, input int churn);
    logic [FUNC_W-1:0] f;
    logic              ce;
    logic              cp;
    int                v[MAX_AXES];
    int                spread;
    int                roll;
    roll = $urandom_range(99);
    f    = FUNC_CAL;
    ce   = 1'b0;
    cp   = 1'b1;
    spread = dev / 3;
    for (int i = 0; i < MAX_AXES; i++) v[i] = int'($urandom_range(65535)) - 32768;
    if (roll < churn) begin
      case ($urandom_range(3))
        0: begin
          f = FUNC_RESTART;
          ce = 1'($urandom_range(1));
          cp = 1'($urandom_range(1));
          for (int i = 0; i < MAX_AXES; i++) center[i] = int'($urandom_range(65535)) - 32768;
        end
        1: begin
          // A clean calibration sample that likely breaks the limit.
          spread = (dev > 20000) ? 40000 : 2 * dev + 10;
          for (int i = 0; i < MAX_AXES; i++) begin
            v[i] = center[i] + int'($urandom_range(2 * spread)) - spread;
          end
        end
        default: begin
          f  = FUNC_W'($urandom_range(3));
          ce = 1'($urandom_range(1));
          cp = 1'($urandom_range(1));
          for (int i = 0; i < MAX_AXES; i++) begin
            case ($urandom_range(7))
              0:       v[i] = -32768;
              1:       v[i] = 32767;
              default: ;
            endcase
          end
        end
      endcase
    end else if (roll < churn + 10) begin
      f = FUNC_MEAS;
    end else begin
      for (int i = 0; i < MAX_AXES; i++) begin
        v[i] = center[i] + int'($urandom_range(2 * spread)) - spread;
      end
    end
    for (int i = 0; i < MAX_AXES; i++) begin
      if (v[i] > 32767) v[i] = 32767;
      else if (v[i] < -32768) v[i] = -32768;
    end
    send_beat(f, ce, cp, v[0], v[1], v[2]);
  endtask

  // A phase sets both registers with the block idle, picks fresh centers and
  // sends a run of random beats. hold_at names the beat at which the long
  // result hold-off starts (negative for none); quiet turns idling off.
  task automatic run_phase(input int dev, input int avg, input int count, input int churn,
                           input int hold_at, input bit quiet);
    drain();
    write_reg(CFG_DEV_LIMIT, dev);
    write_reg(CFG_SAMPLE_TIME, avg);
    for (int i = 0; i < MAX_AXES; i++) begin
      center[i] = int'($urandom_range(60000)) - 30000;
    end
    steady = quiet;
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) holds_asked++;
      random_beat(dev, churn);
    end
    steady = 1'b0;
  endtask

  initial begin
    item.valid      = 1'b0;
    item.func       = FUNC_MEAS;
    item.comm_error = 1'b0;
    item.complete   = 1'b0;
    item.sample_x   = '0;
    item.sample_y   = '0;
    item.sample_z   = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed part with the register defaults (limit 200, sample time 256).
    // A measurement before any calibration sees a zero bias.
    send_beat(FUNC_MEAS, 1'b0, 1'b1, 32767, -32768, 0);
    // The first calibration sample after reset becomes the bias.
    send_beat(FUNC_CAL, 1'b0, 1'b1, -32768, 32767, 100);
    // Measurements against opposite extreme biases give the widest rates.
    send_beat(FUNC_MEAS, 1'b0, 1'b1, 32767, -32768, -1);
    // A comm error wins over an incomplete read, and is reported on a calibration sample too.
    send_beat(FUNC_MEAS, 1'b1, 1'b0, 1, 2, 3);
    send_beat(FUNC_CAL, 1'b1, 1'b1, 4, 5, 6);
    // Incomplete reads report invalid data and leave the state alone.
    send_beat(FUNC_CAL, 1'b0, 1'b0, 7, 8, 9);
    send_beat(FUNC_MEAS, 1'b0, 1'b0, -1, -1, -1);
    // The unused selector reports invalid data whatever the flags say.
    send_beat(FUNC_UNUSED, 1'b0, 1'b1, 10, 11, 12);
    send_beat(FUNC_UNUSED, 1'b1, 1'b0, -10, -11, -12);
    // A restart ignores its flags and samples.
    send_beat(FUNC_RESTART, 1'b1, 1'b0, 12345, -12345, 321);
    send_beat(FUNC_CAL, 1'b0, 1'b1, 0, 0, 0);
    // Exactly at the limit is still inside; the small step truncates to zero.
    send_beat(FUNC_CAL, 1'b0, 1'b1, 200, -200, -200);
    // One past the limit on X schedules a restart.
    send_beat(FUNC_CAL, 1'b0, 1'b1, 201, 0, 0);

    // A sample time of zero acts as one, so the bias follows each sample and
    // success comes on the second clean sample after the reseed.
    drain();
    write_reg(CFG_DEV_LIMIT, 100);
    write_reg(CFG_SAMPLE_TIME, 0);
    send_beat(FUNC_CAL, 1'b0, 1'b1, 0, 0, 0);
    send_beat(FUNC_CAL, 1'b0, 1'b1, 7, -9, 3);
    send_beat(FUNC_CAL, 1'b0, 1'b1, 7, -9, 3);
    // X passes and moves its bias, then Y breaks the limit: Z is left alone,
    // and the following measurement shows the partial update.
    send_beat(FUNC_CAL, 1'b0, 1'b1, 50, 200, 0);
    send_beat(FUNC_MEAS, 1'b0, 1'b1, 0, 0, 0);
    send_beat(FUNC_RESTART, 1'b0, 1'b1, 0, 0, 0);
    send_beat(FUNC_CAL, 1'b0, 1'b1, -5, 5, -5);

    // Random phases. The first runs a full 256-sample calibration to success
    // with no churn; the long stretch without idling is the second phase,
    // with the tightest limit; the third uses the widest limit and the longest
    // average; the fourth carries the long result hold-off.
    run_phase(200, 256, 340, 0, -1, 1'b0);
    run_phase(0, 1, 120, 20, -1, 1'b1);
    run_phase(65535, 65535, 120, 20, -1, 1'b0);
    run_phase(30, 4, 300, 15, 100, 1'b0);
    run_phase(1000, 16, 280, 20, -1, 1'b0);
    run_phase(5, 1, 200, 25, -1, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
